[sv/lskm_pkg.sv]
package lskm_pkg;

  // Default length limit of one line, in bytes (matching stops at LINE_LIMIT-1)
  localparam int unsigned LINE_LIMIT_DEF = 1024;

  // Severity codes
  localparam logic [2:0] LVL_CRIT  = 3'd0;
  localparam logic [2:0] LVL_ERR   = 3'd1;
  localparam logic [2:0] LVL_WARN  = 3'd2;
  localparam logic [2:0] LVL_INFO  = 3'd3;
  localparam logic [2:0] LVL_DEBUG = 3'd4;
  localparam logic [2:0] LVL_NONE  = 3'd5;

  // Keyword patterns, oldest byte in the high byte
  localparam logic [31:0] KW_CRIT  = "CRIT";
  localparam logic [23:0] KW_ERR   = "ERR";
  localparam logic [31:0] KW_WARN  = "WARN";
  localparam logic [31:0] KW_INFO  = "INFO";
  localparam logic [39:0] KW_DEBUG = "DEBUG";
  localparam logic [23:0] KW_DBG   = "DBG";

  // Hit flag positions
  localparam int unsigned FLAG_CRIT  = 0;
  localparam int unsigned FLAG_ERR   = 1;
  localparam int unsigned FLAG_WARN  = 2;
  localparam int unsigned FLAG_INFO  = 3;
  localparam int unsigned FLAG_DEBUG = 4;
  localparam int unsigned FLAG_DBG   = 5;
  localparam int unsigned NUM_FLAGS  = 6;

  // One input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       line_end;
  } lskm_beat_t;

  // Beat handed from the input register to the matcher
  typedef struct packed {
    logic       advance;
    lskm_beat_t beat;
  } lskm_step_t;

  // Fold a..z to upper case, leave every other byte alone
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // First class in priority order that was hit
  function automatic logic [2:0] pick_severity(input logic [NUM_FLAGS-1:0] flags);
    if (flags[FLAG_CRIT]) begin
      return LVL_CRIT;
    end
    if (flags[FLAG_ERR]) begin
      return LVL_ERR;
    end
    if (flags[FLAG_WARN]) begin
      return LVL_WARN;
    end
    if (flags[FLAG_INFO]) begin
      return LVL_INFO;
    end
    if (flags[FLAG_DEBUG] || flags[FLAG_DBG]) begin
      return LVL_DEBUG;
    end
    return LVL_NONE;
  endfunction

endpackage

[sv/lskm_match.sv]
module lskm_match #(
  parameter int unsigned LineLimit = lskm_pkg::LINE_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lskm_pkg::lskm_step_t step_i,
  output logic [2:0]         severity_o
);
  import lskm_pkg::*;

  localparam int unsigned CntW = $clog2(LineLimit);
  localparam logic [CntW-1:0] CntMax = CntW'(LineLimit - 1);

  logic [31:0]          recent_q, recent_d;
  logic [NUM_FLAGS-1:0] found_q, found_d;
  logic [CntW-1:0]      taken_q, taken_d;
  logic                 halted_q, halted_d;

  logic [7:0]           c;
  logic                 take;
  logic                 is_zero;
  logic [NUM_FLAGS-1:0] hits;

  // Fold the byte and compare the window against every keyword
  always_comb begin
    c       = fold_upper(step_i.beat.char_byte);
    take    = step_i.advance && step_i.beat.byte_present && !halted_q && (taken_q != CntMax);
    is_zero = (step_i.beat.char_byte == 8'h00);
    hits    = '0;
    hits[FLAG_CRIT]  = ({recent_q[23:0], c} == KW_CRIT);
    hits[FLAG_ERR]   = ({recent_q[15:0], c} == KW_ERR);
    hits[FLAG_WARN]  = ({recent_q[23:0], c} == KW_WARN);
    hits[FLAG_INFO]  = ({recent_q[23:0], c} == KW_INFO);
    hits[FLAG_DEBUG] = ({recent_q, c} == KW_DEBUG);
    hits[FLAG_DBG]   = ({recent_q[15:0], c} == KW_DBG);
  end

  // Advance the line state; clear it once the line ends
  always_comb begin
    recent_d = recent_q;
    found_d  = found_q;
    taken_d  = taken_q;
    halted_d = halted_q;
    if (take) begin
      taken_d = taken_q + 1'b1;
      if (is_zero) begin
        halted_d = 1'b1;
      end else begin
        recent_d = {recent_q[23:0], c};
        found_d  = found_q | hits;
      end
    end
    severity_o = pick_severity(found_d);
    if (step_i.advance && step_i.beat.line_end) begin
      recent_d = '0;
      found_d  = '0;
      taken_d  = '0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      found_q  <= '0;
      taken_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      recent_q <= recent_d;
      found_q  <= found_d;
      taken_q  <= taken_d;
      halted_q <= halted_d;
    end
  end

  // Line end returns every piece of state to its reset value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.advance && step_i.beat.line_end |=>
      found_q == '0 && taken_q == '0 && !halted_q && recent_q == '0)
    else $error("line state not cleared after line end");

  // A halted line takes no further bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !(step_i.advance && step_i.beat.line_end) |=>
      $stable(taken_q) && $stable(found_q))
    else $error("bytes taken after zero byte");

  // Flags are sticky within a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i.advance && step_i.beat.line_end) |=> (found_q & $past(found_q)) == $past(found_q))
    else $error("hit flag dropped within a line");

endmodule

[sv/log_severity_keyword_matcher_top.sv]
// Path: an accepted beat lands in the input register; its result, if the beat ends a line,
// is loaded into the result register that drives severity_o as the beat leaves the input register.
// Throughput: one beat per cycle; the input register and the result register stall only
// while a finished result waits on out_stall_i and a further line end is queued behind it.
// Reset: rst_ni clears both valid flags and all line state asynchronously.
module log_severity_keyword_matcher_top #(
  parameter int unsigned LINE_LIMIT = lskm_pkg::LINE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       byte_present_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] severity_o
);
  import lskm_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  lskm_beat_t s1_q;
  logic       s1_adv;
  logic       in_take;
  logic       out_valid_q, out_valid_d;
  logic [2:0] sev_q;
  logic [2:0] sev_next;
  lskm_step_t step;

  // Move the held beat on unless it would overwrite a result still waiting
  always_comb begin
    s1_adv     = s1_valid_q && (!s1_q.line_end || !out_valid_q || !out_stall_i);
    in_stall_o = s1_valid_q && !s1_adv;
    in_take    = in_valid_i && !in_stall_o;
    s1_valid_d = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    step.advance = s1_adv;
    step.beat    = s1_q;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.char_byte    <= char_byte_i;
      s1_q.byte_present <= byte_present_i;
      s1_q.line_end     <= line_end_i;
    end
  end

  lskm_match #(
    .LineLimit (LINE_LIMIT)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .severity_o (sev_next)
  );

  // Result register: load on line end, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_q.line_end) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.line_end) begin
      sev_q <= sev_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign severity_o  = sev_q;

  // A new result appears only after a line end leaves the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_q.line_end))
    else $error("result without line end");

  // Severity codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> sev_q <= LVL_NONE)
    else $error("severity code out of range");

  // An accepted beat is held in the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted beat lost");

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(s1_adv && s1_q.line_end))
    else $error("waiting result overwritten");

endmodule
